@@ rtl/pel_pkg.sv @@
package pel_pkg;

	localparam int CH_W      = 8;
	localparam int VAL_W     = 10;
	localparam int COORD_W   = 12;
	localparam int LW_W      = 13;
	localparam int KIND_W    = 3;
	localparam int NUM_STATS = 8;
	localparam int MAX_LINE  = 4096;
	localparam int MAX_ROWS  = 4096;
	localparam int LW_RESET  = 640;

	localparam logic [LW_W-1:0]    LINE_LIMIT = LW_W'(MAX_LINE);
	localparam logic [COORD_W-1:0] ROW_LIMIT  = COORD_W'(MAX_ROWS - 1);

	localparam logic [KIND_W-1:0] KIND_MAX_SUM = 3'd0;
	localparam logic [KIND_W-1:0] KIND_MIN_SUM = 3'd1;
	localparam logic [KIND_W-1:0] KIND_MAX_R   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_MAX_G   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_MAX_B   = 3'd4;
	localparam logic [KIND_W-1:0] KIND_MIN_R   = 3'd5;
	localparam logic [KIND_W-1:0] KIND_MIN_G   = 3'd6;
	localparam logic [KIND_W-1:0] KIND_MIN_B   = 3'd7;

	typedef struct packed {
		logic               valid;
		logic [CH_W-1:0]    red;
		logic [CH_W-1:0]    green;
		logic [CH_W-1:0]    blue;
		logic               frame_end;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} pix_stage_t;

	typedef struct packed {
		logic [VAL_W-1:0]   value;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} stat_t;

	typedef stat_t [NUM_STATS-1:0] stat_set_t;

	function automatic logic is_max_kind(input logic [KIND_W-1:0] k);
		return (k == KIND_MAX_SUM) || (k == KIND_MAX_R) || (k == KIND_MAX_G)
			|| (k == KIND_MAX_B);
	endfunction

endpackage

@@ rtl/pel_front.sv @@
module pel_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pixel_valid,
	output logic                           pixel_stall,
	input  logic [pel_pkg::CH_W-1:0]       red,
	input  logic [pel_pkg::CH_W-1:0]       green,
	input  logic [pel_pkg::CH_W-1:0]       blue,
	input  logic                           frame_end,
	input  logic [pel_pkg::LW_W-1:0]       line_width,
	input  logic                           rep_busy,
	output pel_pkg::pix_stage_t            pix_s1
);

	logic [pel_pkg::COORD_W-1:0] col_q, row_q;
	logic [pel_pkg::LW_W-1:0]    eff_width;
	logic [pel_pkg::LW_W-1:0]    col_next;
	logic                        accept;
	logic                        wrap;

	// a second frame end may not reach the tracker while a report is still pending
	assign pixel_stall = frame_end && (rep_busy || (pix_s1.valid && pix_s1.frame_end));
	assign accept      = pixel_valid && !pixel_stall;

	always_comb begin
		if (line_width == '0) begin
			eff_width = pel_pkg::LW_W'(1);
		end else if (line_width > pel_pkg::LINE_LIMIT) begin
			eff_width = pel_pkg::LINE_LIMIT;
		end else begin
			eff_width = line_width;
		end
		col_next = {1'b0, col_q} + pel_pkg::LW_W'(1);
		wrap     = col_next >= eff_width;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (wrap) begin
				col_q <= '0;
				if (row_q < pel_pkg::ROW_LIMIT) begin
					row_q <= row_q + pel_pkg::COORD_W'(1);
				end
			end else begin
				col_q <= col_next[pel_pkg::COORD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_s1 <= '0;
		end else begin
			pix_s1.valid <= accept;
			if (accept) begin
				pix_s1.red       <= red;
				pix_s1.green     <= green;
				pix_s1.blue      <= blue;
				pix_s1.frame_end <= frame_end;
				pix_s1.x         <= col_q;
				pix_s1.y         <= row_q;
			end
		end
	end

endmodule

@@ rtl/pel_tracker.sv @@
module pel_tracker (
	input  logic                clk,
	input  logic                arst_n,
	input  pel_pkg::pix_stage_t pix_s1,
	output logic                snap_valid,
	output pel_pkg::stat_set_t  snap
);

	pel_pkg::stat_set_t          trk_q;
	logic                        started_q;
	logic [pel_pkg::VAL_W-1:0]   samp [pel_pkg::NUM_STATS];
	logic [pel_pkg::VAL_W-1:0]   sum;

	always_comb begin
		sum = pel_pkg::VAL_W'(pix_s1.red) + pel_pkg::VAL_W'(pix_s1.green)
			+ pel_pkg::VAL_W'(pix_s1.blue);
		samp[pel_pkg::KIND_MAX_SUM] = sum;
		samp[pel_pkg::KIND_MIN_SUM] = sum;
		samp[pel_pkg::KIND_MAX_R]   = pel_pkg::VAL_W'(pix_s1.red);
		samp[pel_pkg::KIND_MAX_G]   = pel_pkg::VAL_W'(pix_s1.green);
		samp[pel_pkg::KIND_MAX_B]   = pel_pkg::VAL_W'(pix_s1.blue);
		samp[pel_pkg::KIND_MIN_R]   = pel_pkg::VAL_W'(pix_s1.red);
		samp[pel_pkg::KIND_MIN_G]   = pel_pkg::VAL_W'(pix_s1.green);
		samp[pel_pkg::KIND_MIN_B]   = pel_pkg::VAL_W'(pix_s1.blue);
	end

	// strict compare: the first pixel of a frame always takes every tracker
	always_comb begin
		logic take;
		take = 1'b0;
		for (int k = 0; k < pel_pkg::NUM_STATS; k++) begin
			if (pel_pkg::is_max_kind(pel_pkg::KIND_W'(k))) begin
				take = !started_q || (samp[k] > trk_q[k].value);
			end else begin
				take = !started_q || (samp[k] < trk_q[k].value);
			end
			if (take) begin
				snap[k].value = samp[k];
				snap[k].x     = pix_s1.x;
				snap[k].y     = pix_s1.y;
			end else begin
				snap[k] = trk_q[k];
			end
		end
	end

	assign snap_valid = pix_s1.valid && pix_s1.frame_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
		end else if (pix_s1.valid) begin
			started_q <= !pix_s1.frame_end;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_s1.valid) begin
			trk_q <= snap;
		end
	end

endmodule

@@ rtl/pel_report.sv @@
module pel_report (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           snap_valid,
	input  pel_pkg::stat_set_t             snap,
	output logic                           rep_busy,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [pel_pkg::KIND_W-1:0]     stat_kind,
	output logic [pel_pkg::VAL_W-1:0]      extreme_value,
	output logic [pel_pkg::COORD_W-1:0]    pos_x,
	output logic [pel_pkg::COORD_W-1:0]    pos_y,
	output logic                           run_last
);

	pel_pkg::stat_set_t          rep_q;
	logic                        busy_q;
	logic [pel_pkg::KIND_W-1:0]  idx_q;
	logic                        load;

	assign rep_busy = busy_q;
	assign load     = busy_q && (!result_valid || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (snap_valid) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (load) begin
			idx_q <= idx_q + pel_pkg::KIND_W'(1);
			if (idx_q == pel_pkg::KIND_MIN_B) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (snap_valid) begin
			rep_q <= snap;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (load) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			stat_kind     <= idx_q;
			extreme_value <= rep_q[idx_q].value;
			pos_x         <= rep_q[idx_q].x;
			pos_y         <= rep_q[idx_q].y;
			run_last      <= (idx_q == pel_pkg::KIND_MIN_B);
		end
	end

	// a new snapshot never lands on a report that is still draining
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		snap_valid |-> !busy_q)
		else $error("snapshot while report pending");

	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && run_last) |-> (stat_kind == pel_pkg::KIND_MIN_B))
		else $error("run_last on wrong kind");

	a_drain_done: assert property (@(posedge clk) disable iff (!arst_n)
		(load && (idx_q == pel_pkg::KIND_MIN_B)) |=> !busy_q)
		else $error("report still busy after last beat");

	a_start_idx: assert property (@(posedge clk) disable iff (!arst_n)
		snap_valid |=> (busy_q && (idx_q == pel_pkg::KIND_MAX_SUM)))
		else $error("report did not start at first kind");

endmodule

@@ rtl/pixel_extrema_locator_core.sv @@
// Pixel extrema locator.
// Pixels enter on the pixel channel (pixel_valid / pixel_stall) in raster order,
// one beat per clock unless stalled; the block counts column and row from line_width.
// It tracks max/min of R+G+B and of each channel with the first position reached.
// A beat with frame_end set closes the frame: that pixel is included, and eight
// result beats follow on the result channel (result_valid / result_stall) in
// stat_kind order 0..7, run_last set on the eighth; trackers restart for the
// next frame. The frame-end beat is registered in pix_s1, then loads the report
// buffer, then the first result; then one per cycle while result_stall is low.
// Throughput is one pixel per cycle while pixel_stall is low, set by the single
// registered compare stage. The eight results wait in a report buffer, so pixels
// of the next frame keep flowing while the report drains; pixel_stall rises only
// for a frame-end beat that arrives before the previous report has moved its last
// beat into the output register. A stalled result beat holds on the output
// register. line_width is written on the cfg channel (always ready); the user must
// write it only while idle, which the block does not enforce. Reset clears the
// position counters and report and restarts the trackers; line_width goes to 640.
module pixel_extrema_locator_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pel_pkg::LW_W-1:0]       cfg_data,
	input  logic                           pixel_valid,
	output logic                           pixel_stall,
	input  logic [pel_pkg::CH_W-1:0]       red,
	input  logic [pel_pkg::CH_W-1:0]       green,
	input  logic [pel_pkg::CH_W-1:0]       blue,
	input  logic                           frame_end,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [pel_pkg::KIND_W-1:0]     stat_kind,
	output logic [pel_pkg::VAL_W-1:0]      extreme_value,
	output logic [pel_pkg::COORD_W-1:0]    pos_x,
	output logic [pel_pkg::COORD_W-1:0]    pos_y,
	output logic                           run_last
);

	logic [pel_pkg::LW_W-1:0] line_width_q;
	pel_pkg::pix_stage_t      pix_s1;
	pel_pkg::stat_set_t       snap;
	logic                     snap_valid;
	logic                     rep_busy;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= pel_pkg::LW_W'(pel_pkg::LW_RESET);
		end else if (cfg_valid && cfg_ready) begin
			line_width_q <= cfg_data;
		end
	end

	pel_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.frame_end   (frame_end),
		.line_width  (line_width_q),
		.rep_busy    (rep_busy),
		.pix_s1      (pix_s1)
	);

	pel_tracker u_tracker (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_s1     (pix_s1),
		.snap_valid (snap_valid),
		.snap       (snap)
	);

	pel_report u_report (
		.clk           (clk),
		.arst_n        (arst_n),
		.snap_valid    (snap_valid),
		.snap          (snap),
		.rep_busy      (rep_busy),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.stat_kind     (stat_kind),
		.extreme_value (extreme_value),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.run_last      (run_last)
	);

endmodule
